// ===== sv/vstf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vstf_pkg
// Shared types and constants of the video stream to framebuffer writer.
// ----------------------------------------------------------------------------
package vstf_pkg;

	localparam int MAX_WIDTH_DEF  = 640;
	localparam int MAX_HEIGHT_DEF = 480;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam int LIN_W  = 19;
	localparam int OFF_W  = 28;
	localparam int WORD_W = 24;

	localparam logic [11:0] SCREEN_W_RST = 12'd640;
	localparam logic [11:0] SCREEN_H_RST = 12'd480;
	localparam logic [15:0] PITCH_RST    = 16'd2560;

	localparam logic [7:0] GREY_MAX = 8'd255;

	localparam logic [7:0] CH_V    = 8'h56;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_0    = 8'h30;

	localparam logic [3:0] HI_MAGIC_END = 4'd5;
	localparam logic [3:0] HI_LAST      = 4'd15;

	typedef enum logic [1:0] {
		CFG_OUTPUT_MODE   = 2'd0,
		CFG_SCREEN_WIDTH  = 2'd1,
		CFG_SCREEN_HEIGHT = 2'd2,
		CFG_ROW_PITCH     = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		OM_RAW = 2'd0,
		OM_565 = 2'd1,
		OM_24  = 2'd2,
		OM_32  = 2'd3
	} out_mode_t;

	typedef enum logic [1:0] {
		HS_NONE      = 2'd0,
		HS_OK        = 2'd1,
		HS_BAD_MAGIC = 2'd2,
		HS_BAD_SIZE  = 2'd3
	} hdr_status_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_HALT    = 2'd2
	} phase_t;

	typedef struct packed {
		logic        is_hdr;
		hdr_status_t status;
		logic [7:0]  data;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

endpackage
`default_nettype wire

// ===== sv/vstf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vstf_front
// Header parser: accepts file bytes, checks the header, queues verdicts and
// payload bytes.
// ----------------------------------------------------------------------------
module vstf_front import vstf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     file_byte,
	input  wire q_flags_t       q_flags,
	output logic                q_push,
	output q_entry_t            q_wdata,
	output logic                hdr_packed,
	output logic [WW-1:0]       hdr_width,
	output logic [HW-1:0]       hdr_height,
	output logic [15:0]         hdr_rate,
	output logic [31:0]         hdr_total
);

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q;
	logic [23:0] hold_q;
	logic        packed_q;
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [15:0] rate_q;
	logic [31:0] total_q;
	logic        acc;
	logic        magic_bad;
	logic        size_bad;
	logic [7:0]  lead_ch;
	logic [15:0] word16;

	assign in_ready = (phase_q == PH_HALT) || !q_flags.full;
	assign acc      = in_valid && in_ready;
	assign word16   = {file_byte, hold_q[7:0]};
	assign size_bad = (width_q == '0) || (height_q == '0) || (rate_q == '0);

	always_comb begin
		unique case (idx_q[1:0])
			2'd0: lead_ch = CH_V;
			2'd1: lead_ch = CH_G;
			2'd2: lead_ch = CH_A;
			2'd3: lead_ch = CH_1;
		endcase
		magic_bad = hold_q[0] || (file_byte != (packed_q ? CH_0 : CH_H));
	end

	always_comb begin
		phase_d = phase_q;
		q_push  = 1'b0;
		q_wdata = '{is_hdr: 1'b1, status: HS_NONE, data: file_byte};
		unique case (phase_q)
			PH_HEADER: begin
				if (acc && idx_q == HI_MAGIC_END && magic_bad) begin
					phase_d = PH_HALT;
					q_push  = 1'b1;
					q_wdata.status = HS_BAD_MAGIC;
				end else if (acc && idx_q == HI_LAST) begin
					phase_d = size_bad ? PH_HALT : PH_PAYLOAD;
					q_push  = 1'b1;
					q_wdata.status = size_bad ? HS_BAD_SIZE : HS_OK;
				end
			end
			PH_PAYLOAD: begin
				q_push = acc;
				q_wdata.is_hdr = 1'b0;
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			hold_q   <= '0;
			packed_q <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			rate_q   <= '0;
			total_q  <= '0;
		end else if (acc && phase_q == PH_HEADER) begin
			idx_q <= idx_q + 4'd1;
			unique case (idx_q)
				4'd0: hold_q <= {23'd0, file_byte != lead_ch};
				4'd1, 4'd2, 4'd3: hold_q[0] <= hold_q[0] | (file_byte != lead_ch);
				4'd4: begin
					packed_q <= (file_byte == CH_B);
					if (file_byte != CH_B && file_byte != CH_3) begin
						hold_q[0] <= 1'b1;
					end
				end
				4'd5: hold_q <= '0;
				4'd6, 4'd8, 4'd10, 4'd12: hold_q <= {16'd0, file_byte};
				4'd7: width_q <= (word16 >= 16'd1 && word16 <= 16'(MAX_WIDTH)) ?
					word16[WW-1:0] : '0;
				4'd9: height_q <= (word16 >= 16'd1 && word16 <= 16'(MAX_HEIGHT)) ?
					word16[HW-1:0] : '0;
				4'd11: rate_q <= word16;
				4'd13: hold_q[15:8] <= file_byte;
				4'd14: hold_q[23:16] <= file_byte;
				4'd15: total_q <= {file_byte, hold_q};
			endcase
		end
	end

	assign hdr_packed = packed_q;
	assign hdr_width  = width_q;
	assign hdr_height = height_q;
	assign hdr_rate   = rate_q;
	assign hdr_total  = total_q;

endmodule
`default_nettype wire

// ===== sv/vstf_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vstf_fifo
// Short queue between the header parser and the pixel writer.
// ----------------------------------------------------------------------------
module vstf_fifo import vstf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t wdata,
	input  wire logic     pop,
	output q_entry_t      rdata,
	output q_flags_t      flags
);

	q_entry_t       mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign flags.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign flags.empty = (cnt_q == '0);
	assign rdata       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/vstf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vstf_back
// Pixel writer: expands queued bytes into pixels, tracks position, converts
// and crops, and holds the result register.
// ----------------------------------------------------------------------------
module vstf_back import vstf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire q_entry_t          q_rdata,
	input  wire q_flags_t          q_flags,
	output logic                   q_pop,
	input  wire logic              hdr_packed,
	input  wire logic [WW-1:0]     hdr_width,
	input  wire logic [HW-1:0]     hdr_height,
	input  wire logic [15:0]       hdr_rate,
	input  wire logic [31:0]       hdr_total,
	input  wire out_mode_t         output_mode,
	input  wire logic [11:0]       screen_width,
	input  wire logic [11:0]       screen_height,
	input  wire logic [15:0]       row_pitch,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   write_valid,
	output logic [OFF_W-1:0]       fb_offset,
	output logic [WORD_W-1:0]      pixel_word,
	output logic [2:0]             pixel_bytes,
	output logic [1:0]             header_status,
	output logic [15:0]            frame_rate,
	output logic                   frame_end,
	output logic                   stream_end,
	output logic                   last
);

	logic              out_valid_q;
	logic              halted_q;
	logic [2:0]        bit_q;
	logic [WW-1:0]     col_q;
	logic [HW-1:0]     row_q;
	logic [LIN_W-1:0]  lin_q;
	logic [OFF_W-1:0]  row_base_q;
	logic [31:0]       done_q;

	logic              wv_q, fend_q, send_q, last_q;
	logic [OFF_W-1:0]  off_q;
	logic [WORD_W-1:0] word_q;
	logic [2:0]        nb_q;
	hdr_status_t       hs_q;
	logic [15:0]       rate_q;

	logic              advance, work, pix, last_pix, fend, halt_hit, visible;
	logic [7:0]        grey;
	logic [2:0]        nb;
	logic [OFF_W-1:0]  col_ext, col_off, pix_off;
	logic [WORD_W-1:0] pix_word;
	logic [WW:0]       col_nx;
	logic [HW:0]       row_nx;
	logic [31:0]       done_nx;

	always_comb begin
		advance  = !out_valid_q || out_ready;
		work     = advance && !q_flags.empty;
		pix      = work && !q_rdata.is_hdr && !halted_q;
		grey     = hdr_packed ? (q_rdata.data[bit_q] ? GREY_MAX : 8'd0) : q_rdata.data;
		col_nx   = {1'b0, col_q} + 1'b1;
		row_nx   = {1'b0, row_q} + 1'b1;
		done_nx  = done_q + 32'd1;
		fend     = (col_nx == {1'b0, hdr_width}) && (row_nx == {1'b0, hdr_height});
		halt_hit = fend && (hdr_total != '0) && (done_nx == hdr_total);
		last_pix = !hdr_packed || (bit_q == 3'd7) || fend;
		q_pop    = work && (q_rdata.is_hdr || halted_q || last_pix);
		visible  = (12'(col_q) < screen_width) && (12'(row_q) < screen_height);
		col_ext  = OFF_W'(col_q);
		unique case (output_mode)
			OM_RAW: begin
				nb = 3'd1;
				col_off = col_ext;
			end
			OM_565: begin
				nb = 3'd2;
				col_off = col_ext << 1;
			end
			OM_24: begin
				nb = 3'd3;
				col_off = (col_ext << 1) + col_ext;
			end
			OM_32: begin
				nb = 3'd4;
				col_off = col_ext << 2;
			end
		endcase
		if (output_mode == OM_RAW) begin
			pix_off  = OFF_W'(lin_q);
			pix_word = WORD_W'(grey);
		end else if (visible) begin
			pix_off  = row_base_q + col_off;
			pix_word = (output_mode == OM_565) ?
				WORD_W'({grey[7:3], grey[7:2], grey[7:3]}) : {grey, grey, grey};
		end else begin
			pix_off  = '0;
			pix_word = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			halted_q    <= 1'b0;
			bit_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			lin_q       <= '0;
			row_base_q  <= '0;
			done_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= work && (q_rdata.is_hdr || !halted_q);
			end
			if (q_pop) begin
				bit_q <= '0;
			end else if (pix) begin
				bit_q <= bit_q + 3'd1;
			end
			if (work && q_rdata.is_hdr) begin
				halted_q   <= (q_rdata.status != HS_OK);
				col_q      <= '0;
				row_q      <= '0;
				lin_q      <= '0;
				row_base_q <= '0;
				done_q     <= '0;
			end else if (pix) begin
				if (fend) begin
					done_q     <= done_nx;
					col_q      <= '0;
					row_q      <= '0;
					lin_q      <= '0;
					row_base_q <= '0;
					if (halt_hit) begin
						halted_q <= 1'b1;
					end
				end else begin
					lin_q <= lin_q + 1'b1;
					if (col_nx == {1'b0, hdr_width}) begin
						col_q      <= '0;
						row_q      <= row_nx[HW-1:0];
						row_base_q <= row_base_q + OFF_W'(row_pitch);
					end else begin
						col_q <= col_nx[WW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work && q_rdata.is_hdr) begin
			wv_q   <= 1'b0;
			off_q  <= '0;
			word_q <= '0;
			nb_q   <= 3'd1;
			hs_q   <= q_rdata.status;
			rate_q <= (q_rdata.status == HS_OK) ? hdr_rate : 16'd0;
			fend_q <= 1'b0;
			send_q <= 1'b0;
			last_q <= 1'b1;
		end else if (pix) begin
			wv_q   <= (output_mode == OM_RAW) || visible;
			off_q  <= pix_off;
			word_q <= pix_word;
			nb_q   <= nb;
			hs_q   <= HS_NONE;
			rate_q <= 16'd0;
			fend_q <= fend;
			send_q <= halt_hit;
			last_q <= last_pix;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_valid   = wv_q;
	assign fb_offset     = off_q;
	assign pixel_word    = word_q;
	assign pixel_bytes   = nb_q;
	assign header_status = hs_q;
	assign frame_rate    = rate_q;
	assign frame_end     = fend_q;
	assign stream_end    = send_q;
	assign last          = last_q;

endmodule
`default_nettype wire

// ===== sv/video_stream_to_framebuffer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// video_stream_to_framebuffer_top
// Raw video file parser that turns file bytes into framebuffer writes.
//
// Input channel in_valid/in_ready/file_byte takes one file byte per
// transaction: a 16-byte header, then frame payload. Output channel
// out_valid/out_ready carries one result per transaction: a header verdict
// or one pixel write; last marks the final result of a byte.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data is always ready;
// write it only while the block is idle.
// The accepting edge writes a payload byte or header verdict into the queue;
// the result register is loaded from the queue head once it can advance.
// Throughput: one byte per cycle for 8-bit frames while results are taken;
// packed frames expand each byte into up to eight single-pixel writes.
// When the receiver stalls the result register holds, the four-entry queue
// fills and in_ready drops. Bytes after a rejected header or the last
// counted frame are accepted and dropped.
// Reset puts the parser in header phase and loads the register defaults
// (raw mode, 640 x 480 screen, pitch 2560).
// ----------------------------------------------------------------------------
module video_stream_to_framebuffer_top import vstf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        file_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   write_valid,
	output logic [OFF_W-1:0]       fb_offset,
	output logic [WORD_W-1:0]      pixel_word,
	output logic [2:0]             pixel_bytes,
	output logic [1:0]             header_status,
	output logic [15:0]            frame_rate,
	output logic                   frame_end,
	output logic                   stream_end,
	output logic                   last,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	out_mode_t     mode_q;
	logic [11:0]   scr_w_q, scr_h_q;
	logic [15:0]   pitch_q;

	q_flags_t      q_flags;
	q_entry_t      q_wdata, q_rdata;
	logic          q_push, q_pop;
	logic          hdr_packed;
	logic [WW-1:0] hdr_width;
	logic [HW-1:0] hdr_height;
	logic [15:0]   hdr_rate;
	logic [31:0]   hdr_total;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= OM_RAW;
			scr_w_q <= SCREEN_W_RST;
			scr_h_q <= SCREEN_H_RST;
			pitch_q <= PITCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_OUTPUT_MODE:   mode_q  <= out_mode_t'(cfg_data[1:0]);
				CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data[11:0];
				CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data[11:0];
				CFG_ROW_PITCH:     pitch_q <= cfg_data;
			endcase
		end
	end

	vstf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.file_byte  (file_byte),
		.q_flags    (q_flags),
		.q_push     (q_push),
		.q_wdata    (q_wdata),
		.hdr_packed (hdr_packed),
		.hdr_width  (hdr_width),
		.hdr_height (hdr_height),
		.hdr_rate   (hdr_rate),
		.hdr_total  (hdr_total)
	);

	vstf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.flags  (q_flags)
	);

	vstf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_rdata       (q_rdata),
		.q_flags       (q_flags),
		.q_pop         (q_pop),
		.hdr_packed    (hdr_packed),
		.hdr_width     (hdr_width),
		.hdr_height    (hdr_height),
		.hdr_rate      (hdr_rate),
		.hdr_total     (hdr_total),
		.output_mode   (mode_q),
		.screen_width  (scr_w_q),
		.screen_height (scr_h_q),
		.row_pitch     (pitch_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_valid   (write_valid),
		.fb_offset     (fb_offset),
		.pixel_word    (pixel_word),
		.pixel_bytes   (pixel_bytes),
		.header_status (header_status),
		.frame_rate    (frame_rate),
		.frame_end     (frame_end),
		.stream_end    (stream_end),
		.last          (last)
	);

	a_hdr_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_status != HS_NONE |-> !write_valid && last && !frame_end)
		else $error("header verdict with pixel fields");

	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> frame_end && last)
		else $error("stream end outside frame end");

	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last)
		else $error("frame end not last of byte");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_flags.full && q_flags.empty))
		else $error("queue full and empty");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_flags.empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire
